[design/mfd_pkg.sv]
// Shared types and constants for the motor feedback decoder.
package mfd_pkg;

    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 192;

    localparam int CODE_IN_W = 13;
    localparam int SPEED_W   = 16;
    localparam int CURRENT_W = 16;
    localparam int BYTE_W    = 8;

    localparam int SINGLE_W = 20;
    localparam int FILT_W   = 24;
    localparam int PHASE_W  = 20;
    localparam int TOTAL_W  = 38;
    localparam int RAD_W    = 21;
    localparam int TURN_W   = 32;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int SCALE_W    = 16;

    localparam logic [CFG_ADDR_W-1:0] CFG_REVERSE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SCALE   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_STATUS  = 2'd2;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd20480;

    localparam logic [S_TUSER_W-1:0] OP_FRAME  = 2'd0;
    localparam logic [S_TUSER_W-1:0] OP_REZERO = 2'd1;
    localparam logic [S_TUSER_W-1:0] OP_CLEAR  = 2'd2;

    // speed filter: floor(n / 25) by reciprocal, n biased to non-negative
    localparam int              FILT_SUM_W = 30;
    localparam logic [30:0]     DIV25_BIAS = 31'd419430400;  // 25 * 2^24
    localparam logic [30:0]     DIV25_RECIP = 31'd1374389535; // ceil(2^35 / 25)
    localparam int              DIV25_SHIFT = 35;
    localparam logic [24:0]     DIV25_UNBIAS = 25'd16777216; // 2^24

    // 0.10472 rad/s per rpm, Q24
    localparam logic signed [37:0] RAD_SCALE = 38'sd1756910;

    typedef struct packed {
        logic fire;
        logic frame;
        logic rezero;
        logic clear;
        logic reverse;
    } mfd_ctrl_t;

endpackage

[design/mfd_unwrap.sv]
// Encoder unwrap: turn and position counts, angle conversion.
module mfd_unwrap #(
    parameter int COUNT_WIDTH    = 32,
    parameter int CODES_PER_TURN = 8192
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  mfd_pkg::mfd_ctrl_t                 ctrl,
    input  logic [mfd_pkg::CODE_IN_W-1:0]      encoder_code,
    output logic signed [mfd_pkg::SINGLE_W-1:0] single_angle,
    output logic signed [mfd_pkg::TOTAL_W-1:0]  total_angle,
    output logic signed [mfd_pkg::TURN_W-1:0]   turn_count,
    output logic signed [mfd_pkg::SINGLE_W-1:0] offset_angle
);

    localparam int CODE_W = $clog2(CODES_PER_TURN);
    localparam int EXT_W  = (CODE_W > mfd_pkg::CODE_IN_W) ? CODE_W : mfd_pkg::CODE_IN_W;
    localparam int DW     = CODE_W + 2;
    localparam int CW     = COUNT_WIDTH;
    localparam int AW     = COUNT_WIDTH + 22;

    localparam logic signed [DW-1:0] HALF_TURN = DW'(CODES_PER_TURN / 2);
    localparam logic signed [DW-1:0] FULL_TURN = DW'(CODES_PER_TURN);
    localparam logic signed [CW:0]   COUNT_MAX = (CW+1)'((64'd1 << (CW - 1)) - 64'd1);
    localparam logic signed [CW:0]   COUNT_MIN = -COUNT_MAX - (CW+1)'(1);
    localparam logic signed [AW-1:0] ANG_HALF  = AW'(CODES_PER_TURN / 2);

    logic                  started_reg, started_next;
    logic [CODE_W-1:0]     prior_reg, prior_next;
    logic [CODE_W-1:0]     first_reg, first_next;
    logic signed [mfd_pkg::TURN_W-1:0] wrap_reg, wrap_next;
    logic signed [CW-1:0]  pos_reg, pos_next;

    logic [EXT_W-1:0]      code_ext;
    logic [CODE_W-1:0]     code;
    logic [CODE_W-1:0]     start_code;
    logic signed [DW-1:0]  delta;
    logic signed [DW-1:0]  delta_adj;
    logic signed [mfd_pkg::TURN_W-1:0] wrap_adj;
    logic signed [CW:0]    pos_sum;
    logic signed [CW-1:0]  pos_sat;
    logic signed [AW-1:0]  single_full;
    logic signed [AW-1:0]  total_full;
    logic signed [AW-1:0]  offset_full;

    // counts * 360 deg * 1024 / CODES_PER_TURN, rounded half up
    function automatic logic signed [AW-1:0] to_angle(input logic signed [CW:0] cnt,
                                                      input logic rev);
        logic signed [AW-1:0] x;
        logic signed [AW-1:0] p;
        logic signed [AW-1:0] a;
        x = AW'(cnt);
        p = (x <<< 5) + (x <<< 3) + (x <<< 2) + x;
        a = ((p <<< 13) + ANG_HALF) >>> CODE_W;
        return rev ? -a : a;
    endfunction

    always_comb begin
        code_ext   = EXT_W'(encoder_code);
        code       = code_ext[CODE_W-1:0];
        start_code = started_reg ? prior_reg : code;
        delta      = DW'($signed({1'b0, code})) - DW'($signed({1'b0, start_code}));
        delta_adj  = delta;
        wrap_adj   = wrap_reg;
        if (delta > HALF_TURN) begin
            delta_adj = delta - FULL_TURN;
            wrap_adj  = wrap_reg - mfd_pkg::TURN_W'(1);
        end else if (delta < -HALF_TURN) begin
            delta_adj = delta + FULL_TURN;
            wrap_adj  = wrap_reg + mfd_pkg::TURN_W'(1);
        end
        pos_sum = (CW+1)'(pos_reg) + (CW+1)'(delta_adj);
        if (pos_sum > COUNT_MAX) begin
            pos_sat = COUNT_MAX[CW-1:0];
        end else if (pos_sum < COUNT_MIN) begin
            pos_sat = COUNT_MIN[CW-1:0];
        end else begin
            pos_sat = pos_sum[CW-1:0];
        end
    end

    always_comb begin
        started_next = started_reg;
        prior_next   = prior_reg;
        first_next   = first_reg;
        wrap_next    = wrap_reg;
        pos_next     = pos_reg;
        if (ctrl.fire) begin
            if (ctrl.frame) begin
                started_next = 1'b1;
                prior_next   = code;
                first_next   = started_reg ? first_reg : code;
                wrap_next    = wrap_adj;
                pos_next     = pos_sat;
            end else if (ctrl.rezero) begin
                wrap_next = '0;
                pos_next  = '0;
            end else if (ctrl.clear) begin
                started_next = 1'b0;
                prior_next   = '0;
                first_next   = '0;
                wrap_next    = '0;
                pos_next     = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg <= 1'b0;
            prior_reg   <= '0;
            first_reg   <= '0;
            wrap_reg    <= '0;
            pos_reg     <= '0;
        end else begin
            started_reg <= started_next;
            prior_reg   <= prior_next;
            first_reg   <= first_next;
            wrap_reg    <= wrap_next;
            pos_reg     <= pos_next;
        end
    end

    always_comb begin
        single_full = to_angle($signed((CW+1)'(prior_next)), ctrl.reverse);
        offset_full = to_angle($signed((CW+1)'(first_next)), ctrl.reverse);
        total_full  = to_angle((CW+1)'(pos_next), ctrl.reverse);
    end

    assign single_angle = single_full[mfd_pkg::SINGLE_W-1:0];
    assign offset_angle = offset_full[mfd_pkg::SINGLE_W-1:0];
    assign total_angle  = total_full[mfd_pkg::TOTAL_W-1:0];
    assign turn_count   = wrap_next;

endmodule

[design/mfd_speed_filter.sv]
// Speed IIR filter with 24/25 weight on the new sample.
module mfd_speed_filter (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  mfd_pkg::mfd_ctrl_t                  ctrl,
    input  logic signed [mfd_pkg::SPEED_W-1:0]  rotor_speed,
    output logic signed [mfd_pkg::FILT_W-1:0]   filtered_speed
);

    localparam int NW = mfd_pkg::FILT_SUM_W;
    localparam logic signed [mfd_pkg::FILT_W-1:0] FILT_MIN = {1'b1, {(mfd_pkg::FILT_W-1){1'b0}}};
    localparam logic signed [mfd_pkg::FILT_W-1:0] FILT_MAX = {1'b0, {(mfd_pkg::FILT_W-1){1'b1}}};

    logic                                 primed_reg, primed_next;
    logic signed [mfd_pkg::FILT_W-1:0]    mem_reg, mem_next;

    logic signed [NW-1:0]  spd_ext;
    logic signed [NW-1:0]  sum;
    logic [30:0]           biased;
    logic [60:0]           prod;
    logic [24:0]           quot;
    logic [24:0]           unbiased;

    always_comb begin
        spd_ext  = NW'(rotor_speed);
        sum      = (spd_ext <<< 12) + (spd_ext <<< 11) + NW'(mem_reg) + NW'(12);
        biased   = 31'($signed(sum)) + mfd_pkg::DIV25_BIAS;
        prod     = 61'(biased[NW-1:0]) * 61'(mfd_pkg::DIV25_RECIP);
        quot     = prod[mfd_pkg::DIV25_SHIFT+24:mfd_pkg::DIV25_SHIFT];
        unbiased = quot - mfd_pkg::DIV25_UNBIAS;
    end

    always_comb begin
        primed_next = primed_reg;
        mem_next    = mem_reg;
        if (ctrl.fire) begin
            if (ctrl.frame) begin
                primed_next = 1'b1;
                mem_next    = primed_reg ? $signed(unbiased[mfd_pkg::FILT_W-1:0])
                                         : $signed({rotor_speed, 8'd0});
            end else if (ctrl.clear) begin
                primed_next = 1'b0;
                mem_next    = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            primed_reg <= 1'b0;
            mem_reg    <= '0;
        end else begin
            primed_reg <= primed_next;
            mem_reg    <= mem_next;
        end
    end

    always_comb begin
        if (!ctrl.reverse) begin
            filtered_speed = mem_next;
        end else if (mem_next == FILT_MIN) begin
            filtered_speed = FILT_MAX;
        end else begin
            filtered_speed = -mem_next;
        end
    end

endmodule

[design/mfd_scale.sv]
// Phase current and speed-in-radians scaling.
module mfd_scale (
    input  logic                                 frame,
    input  logic                                 reverse,
    input  logic [mfd_pkg::SCALE_W-1:0]          current_scale,
    input  logic signed [mfd_pkg::CURRENT_W-1:0] current_code,
    input  logic signed [mfd_pkg::SPEED_W-1:0]   rotor_speed,
    output logic signed [mfd_pkg::PHASE_W-1:0]   phase_current,
    output logic signed [mfd_pkg::RAD_W-1:0]     speed_radians
);

    logic signed [32:0] cur_prod;
    logic signed [32:0] cur_shift;
    logic signed [20:0] cur_val;
    logic signed [37:0] rad_prod;
    logic signed [37:0] rad_shift;
    logic signed [21:0] rad_val;

    always_comb begin
        cur_prod  = 33'(current_code) * $signed({17'd0, current_scale});
        cur_shift = (cur_prod + 33'sd2048) >>> 12;
        cur_val   = reverse ? -cur_shift[20:0] : cur_shift[20:0];
        rad_prod  = 38'(rotor_speed) * mfd_pkg::RAD_SCALE;
        rad_shift = (rad_prod + 38'sd32768) >>> 16;
        rad_val   = reverse ? -rad_shift[21:0] : rad_shift[21:0];
        phase_current = frame ? cur_val[mfd_pkg::PHASE_W-1:0] : '0;
        speed_radians = frame ? rad_val[mfd_pkg::RAD_W-1:0] : '0;
    end

endmodule

[design/motor_feedback_decoder.sv]
// Motor feedback decoder top level: request register, state units, result register.
//
//  channel   direction  ports                        tdata / tuser contents
//  s_        in         s_tvalid s_tready s_tdata    frame fields, op in s_tuser
//  m_        out        m_tvalid m_tready m_tdata    decoded angles, speed, current
//  cfg_      in         cfg_we cfg_addr cfg_data     reverse, current scale, status
//
// One request per cycle while m_tready does not hold the result; an accepted request
// passes through the request register, then the result register. Unwrap and filter
// state update in the same cycle a request moves into the result register, through
// the position add and the divide-by-25 reciprocal multiply. aresetn clears state and
// valids and restores the configuration defaults.
// With m_tready low the result holds and one further request waits in the
// request register.
module motor_feedback_decoder #(
    parameter int COUNT_WIDTH    = 32,
    parameter int CODES_PER_TURN = 8192
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [12:0] encoder_code, [28:13] rotor_speed, [44:29] current_code,
    // [52:45] temperature, [60:53] extra_byte
    input  logic [mfd_pkg::S_TDATA_W-1:0]     s_tdata,
    // [1:0] operation
    input  logic [mfd_pkg::S_TUSER_W-1:0]     s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [19:0] single_angle, [43:20] filtered_speed, [63:44] phase_current,
    // [101:64] total_angle, [122:102] speed_radians, [130:123] temperature_out,
    // [138:131] extra_out, [170:139] turn_count, [190:171] offset_angle
    output logic [mfd_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                              cfg_we,
    input  logic [mfd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [mfd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic                               reverse_reg;
    logic [mfd_pkg::SCALE_W-1:0]        scale_reg;
    logic                               status_reg;

    logic                               in_valid_reg, in_valid_next;
    logic [mfd_pkg::S_TUSER_W-1:0]      op_reg;
    logic [mfd_pkg::CODE_IN_W-1:0]      code_reg;
    logic signed [mfd_pkg::SPEED_W-1:0] speed_reg;
    logic signed [mfd_pkg::CURRENT_W-1:0] current_reg;
    logic [mfd_pkg::BYTE_W-1:0]         temp_reg;
    logic [mfd_pkg::BYTE_W-1:0]         extra_reg;

    logic                               m_valid_reg, m_valid_next;
    logic [mfd_pkg::M_TDATA_W-1:0]      m_data_reg, m_data_next;

    logic                               out_ready;
    logic                               advance;
    logic                               s_fire;
    mfd_pkg::mfd_ctrl_t                 ctrl;

    logic signed [mfd_pkg::SINGLE_W-1:0] single_angle;
    logic signed [mfd_pkg::TOTAL_W-1:0]  total_angle;
    logic signed [mfd_pkg::TURN_W-1:0]   turn_count;
    logic signed [mfd_pkg::SINGLE_W-1:0] offset_angle;
    logic signed [mfd_pkg::FILT_W-1:0]   filtered_speed;
    logic signed [mfd_pkg::PHASE_W-1:0]  phase_current;
    logic signed [mfd_pkg::RAD_W-1:0]    speed_radians;
    logic [mfd_pkg::BYTE_W-1:0]          temp_out;
    logic [mfd_pkg::BYTE_W-1:0]          extra_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reverse_reg <= 1'b0;
            scale_reg   <= mfd_pkg::SCALE_RESET;
            status_reg  <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                mfd_pkg::CFG_REVERSE: reverse_reg <= cfg_data[0];
                mfd_pkg::CFG_SCALE:   scale_reg   <= cfg_data[mfd_pkg::SCALE_W-1:0];
                mfd_pkg::CFG_STATUS:  status_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign out_ready = !m_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;
    assign s_fire    = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            op_reg      <= s_tuser;
            code_reg    <= s_tdata[12:0];
            speed_reg   <= $signed(s_tdata[28:13]);
            current_reg <= $signed(s_tdata[44:29]);
            temp_reg    <= s_tdata[52:45];
            extra_reg   <= s_tdata[60:53];
        end
        if (advance) begin
            m_data_reg <= m_data_next;
        end
    end

    always_comb begin
        ctrl         = '0;
        ctrl.fire    = advance;
        ctrl.reverse = reverse_reg;
        unique case (op_reg)
            mfd_pkg::OP_FRAME:  ctrl.frame  = 1'b1;
            mfd_pkg::OP_REZERO: ctrl.rezero = 1'b1;
            mfd_pkg::OP_CLEAR:  ctrl.clear  = 1'b1;
            default: ;
        endcase
    end

    mfd_unwrap #(
        .COUNT_WIDTH    (COUNT_WIDTH),
        .CODES_PER_TURN (CODES_PER_TURN)
    ) u_unwrap (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (ctrl),
        .encoder_code (code_reg),
        .single_angle (single_angle),
        .total_angle  (total_angle),
        .turn_count   (turn_count),
        .offset_angle (offset_angle)
    );

    mfd_speed_filter u_filter (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl           (ctrl),
        .rotor_speed    (speed_reg),
        .filtered_speed (filtered_speed)
    );

    mfd_scale u_scale (
        .frame         (ctrl.frame),
        .reverse       (reverse_reg),
        .current_scale (scale_reg),
        .current_code  (current_reg),
        .rotor_speed   (speed_reg),
        .phase_current (phase_current),
        .speed_radians (speed_radians)
    );

    always_comb begin
        temp_out    = (ctrl.frame && status_reg) ? temp_reg : '0;
        extra_out   = (ctrl.frame && status_reg) ? extra_reg : '0;
        m_data_next = {1'b0, offset_angle, turn_count, extra_out, temp_out, speed_radians,
                       total_angle, phase_current, filtered_speed, single_angle};
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the motor feedback decoder: directed and random requests.
module tb_top;

    localparam logic [mfd_pkg::S_TUSER_W-1:0] OP_UNUSED = 2'd3;

    localparam longint TURN_CODES      = 8192;
    localparam longint HALF_TURN       = 4096;
    localparam longint TURN_Q10        = 368640;
    localparam longint RAD_PER_RPM_Q24 = 1756910;
    localparam longint COUNT_MAX       = 64'sd2147483647;
    localparam longint SPEED_MAX       = 8388607;
    localparam int     BACKLOG_CYCLES  = 150;
    localparam int     DRAIN_LIMIT     = 20000;
    localparam int     SEGMENT_LEN     = 50;

    typedef struct packed {
        logic                               pad;
        logic [mfd_pkg::SINGLE_W-1:0]       offset_angle;
        logic [31:0]                        turn_count;
        logic [mfd_pkg::BYTE_W-1:0]         extra_out;
        logic [mfd_pkg::BYTE_W-1:0]         temperature_out;
        logic [mfd_pkg::RAD_W-1:0]          speed_radians;
        logic [mfd_pkg::TOTAL_W-1:0]        total_angle;
        logic [mfd_pkg::PHASE_W-1:0]        phase_current;
        logic [mfd_pkg::FILT_W-1:0]         filtered_speed;
        logic [mfd_pkg::SINGLE_W-1:0]       single_angle;
    } feedback_result_t;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [mfd_pkg::S_TDATA_W-1:0]  s_tdata  = '0;
    logic [mfd_pkg::S_TUSER_W-1:0]  s_tuser  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [mfd_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                           cfg_we   = 1'b0;
    logic [mfd_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [mfd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // predictor copy of configuration and decoder state
    logic        dir_reverse   = 1'b0;
    logic [15:0] amps_scale    = mfd_pkg::SCALE_RESET;
    logic        bytes_enabled = 1'b1;
    logic        unwrap_started;
    logic [12:0] prior_code;
    logic [12:0] first_code;
    logic [31:0] wrap_count;
    longint      position_count;
    logic        filter_primed;
    longint      speed_memory;

    feedback_result_t pending_decodes[$];

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          backlog_left  = 0;
    int          mismatch_count = 0;
    int          results_checked = 0;
    int          op_count[4] = '{0, 0, 0, 0};
    int          settings_applied = 0;
    logic [12:0] walk_code = '0;

    motor_feedback_decoder u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) begin
            q = q - 1;
        end
        return q;
    endfunction

    function automatic longint apply_direction(longint v);
        return dir_reverse ? -v : v;
    endfunction

    function automatic longint counts_to_q10(longint counts);
        longint hi;
        longint lo;
        hi = floor_div(counts, TURN_CODES);
        lo = counts - hi * TURN_CODES;
        return hi * TURN_Q10 + (lo * TURN_Q10 + TURN_CODES / 2) / TURN_CODES;
    endfunction

    function automatic void clear_decoder();
        unwrap_started = 1'b0;
        prior_code     = '0;
        first_code     = '0;
        wrap_count     = '0;
        position_count = 0;
        filter_primed  = 1'b0;
        speed_memory   = 0;
    endfunction

    function automatic feedback_result_t advance_decoder(logic [1:0] op, logic [12:0] code,
            logic signed [15:0] spd, logic signed [15:0] cur, logic [7:0] temp,
            logic [7:0] extra);
        feedback_result_t r;
        longint step;
        longint filt;
        longint phase;
        longint rad;
        r     = '0;
        phase = 0;
        rad   = 0;
        if (op == mfd_pkg::OP_FRAME) begin
            if (!unwrap_started) begin
                prior_code     = code;
                first_code     = code;
                unwrap_started = 1'b1;
            end
            step = longint'(code) - longint'(prior_code);
            if (step > HALF_TURN) begin
                wrap_count = wrap_count - 1;
                step       = step - TURN_CODES;
            end else if (step < -HALF_TURN) begin
                wrap_count = wrap_count + 1;
                step       = step + TURN_CODES;
            end
            position_count = position_count + step;
            if (position_count > COUNT_MAX) begin
                position_count = COUNT_MAX;
            end
            if (position_count < -COUNT_MAX - 1) begin
                position_count = -COUNT_MAX - 1;
            end
            prior_code = code;
            if (!filter_primed) begin
                speed_memory  = longint'(spd) * 256;
                filter_primed = 1'b1;
            end else begin
                speed_memory = floor_div(longint'(spd) * 6144 + speed_memory + 12, 25);
            end
            phase = apply_direction(floor_div(longint'(cur) * longint'(amps_scale) + 2048,
                                              4096));
            rad   = apply_direction(floor_div(longint'(spd) * RAD_PER_RPM_Q24 + 32768, 65536));
            if (bytes_enabled) begin
                r.temperature_out = temp;
                r.extra_out       = extra;
            end
        end else if (op == mfd_pkg::OP_REZERO) begin
            wrap_count     = '0;
            position_count = 0;
        end else if (op == mfd_pkg::OP_CLEAR) begin
            clear_decoder();
        end
        filt = apply_direction(speed_memory);
        if (filt > SPEED_MAX) begin
            filt = SPEED_MAX;
        end
        r.single_angle   = mfd_pkg::SINGLE_W'(apply_direction(counts_to_q10(longint'(prior_code))));
        r.filtered_speed = mfd_pkg::FILT_W'(filt);
        r.phase_current  = mfd_pkg::PHASE_W'(phase);
        r.total_angle    = mfd_pkg::TOTAL_W'(apply_direction(counts_to_q10(position_count)));
        r.speed_radians  = mfd_pkg::RAD_W'(rad);
        r.turn_count     = wrap_count;
        r.offset_angle   = mfd_pkg::SINGLE_W'(apply_direction(counts_to_q10(longint'(first_code))));
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= 40) begin
            $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        end
    endtask

    task automatic send_request(logic [1:0] op, logic [12:0] code, logic [15:0] spd,
            logic [15:0] cur, logic [7:0] temp, logic [7:0] extra);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, extra, temp, cur, spd, code};
        do begin
            @(posedge aclk);
        end while (!s_tready);
        pending_decodes.push_back(advance_decoder(op, code, spd, cur, temp, extra));
        op_count[op]++;
        walk_code = code;
    endtask

    task automatic wait_drained();
        int n;
        s_tvalid <= 1'b0;
        for (n = 0; n < DRAIN_LIMIT && pending_decodes.size() != 0; n++) begin
            @(posedge aclk);
        end
        if (pending_decodes.size() != 0) begin
            report_mismatch("results never delivered", pending_decodes.size(), 0);
            pending_decodes.delete();
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic apply_settings(logic rev, logic [15:0] scale, logic status);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_addr <= mfd_pkg::CFG_REVERSE;
        cfg_data <= {15'b0, rev};
        @(posedge aclk);
        cfg_addr <= mfd_pkg::CFG_SCALE;
        cfg_data <= scale;
        @(posedge aclk);
        cfg_addr <= mfd_pkg::CFG_STATUS;
        cfg_data <= {15'b0, status};
        @(posedge aclk);
        cfg_we        <= 1'b0;
        dir_reverse   = rev;
        amps_scale    = scale;
        bytes_enabled = status;
        settings_applied++;
    endtask

    task automatic send_random_request();
        int          pick;
        logic [1:0]  op;
        logic [12:0] code;
        pick = $urandom_range(99);
        if (pick < 85) begin
            op = mfd_pkg::OP_FRAME;
        end else if (pick < 91) begin
            op = mfd_pkg::OP_REZERO;
        end else if (pick < 95) begin
            op = mfd_pkg::OP_CLEAR;
        end else begin
            op = OP_UNUSED;
        end
        pick = $urandom_range(9);
        if (pick == 0) begin
            code = 13'($urandom);
        end else if (pick < 3) begin
            code = walk_code + 13'(4094 + $urandom_range(4));
        end else begin
            code = walk_code + 13'($urandom_range(800)) - 13'd400;
        end
        send_request(op, code, 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic test_reset_defaults();
        send_request(OP_UNUSED, 13'd77, 16'h1234, 16'h4321, 8'd9, 8'd9);
        send_request(mfd_pkg::OP_FRAME, 13'd1234, 16'd1000, 16'd500, 8'd40, 8'd7);
        send_request(mfd_pkg::OP_FRAME, 13'd8191, 16'h7FFF, 16'h7FFF, 8'hFF, 8'hFF);
        send_request(mfd_pkg::OP_FRAME, 13'd0, 16'h8000, 16'h8000, 8'h00, 8'h00);
    endtask

    task automatic test_unwrap_boundaries();
        send_request(mfd_pkg::OP_CLEAR, 13'd0, 16'd0, 16'd0, 8'd0, 8'd0);
        send_request(mfd_pkg::OP_FRAME, 13'd0, 16'd300, 16'd10, 8'd1, 8'd2);
        send_request(mfd_pkg::OP_FRAME, 13'd4096, 16'd300, 16'd10, 8'd1, 8'd2);
        send_request(mfd_pkg::OP_FRAME, 13'd0, 16'hFED4, 16'd10, 8'd1, 8'd2);
        send_request(mfd_pkg::OP_FRAME, 13'd4097, 16'hFED4, 16'd10, 8'd1, 8'd2);
        send_request(mfd_pkg::OP_FRAME, 13'd0, 16'd300, 16'd10, 8'd1, 8'd2);
    endtask

    task automatic test_config_extremes();
        apply_settings(1'b1, 16'hFFFF, 1'b0);
        send_request(mfd_pkg::OP_CLEAR, 13'd5, 16'd0, 16'd0, 8'd0, 8'd0);
        send_request(mfd_pkg::OP_FRAME, 13'd8191, 16'h8000, 16'h8000, 8'hAA, 8'h55);
        send_request(OP_UNUSED, 13'd0, 16'd0, 16'd0, 8'd0, 8'd0);
        send_request(mfd_pkg::OP_FRAME, 13'd100, 16'h7FFF, 16'h7FFF, 8'hFF, 8'hFF);
        apply_settings(1'b0, 16'h0000, 1'b1);
        send_request(mfd_pkg::OP_FRAME, 13'd200, 16'd0, 16'h8000, 8'h5A, 8'hA5);
    endtask

    task automatic test_rezero_clear();
        apply_settings(1'b0, mfd_pkg::SCALE_RESET, 1'b1);
        send_request(mfd_pkg::OP_REZERO, 13'd0, 16'd0, 16'd0, 8'd0, 8'd0);
        send_request(mfd_pkg::OP_FRAME, 13'd6000, 16'd50, 16'd60, 8'd70, 8'd80);
        send_request(mfd_pkg::OP_CLEAR, 13'd0, 16'd0, 16'd0, 8'd0, 8'd0);
        send_request(OP_UNUSED, 13'd0, 16'd0, 16'd0, 8'd0, 8'd0);
    endtask

    task automatic test_backpressure();
        int n;
        apply_settings(1'($urandom), 16'($urandom), 1'b1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        backlog_left <= BACKLOG_CYCLES;
        for (n = 0; n < 30; n++) begin
            send_random_request();
        end
        wait_drained();
    endtask

    task automatic test_random_traffic(int count, int send_pct, int recv_pct);
        int n;
        int pick;
        logic [15:0] scale;
        wait_drained();
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (n = 0; n < count; n++) begin
            if (n % SEGMENT_LEN == 0) begin
                pick = $urandom_range(3);
                scale = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF :
                        (pick == 2) ? mfd_pkg::SCALE_RESET : 16'($urandom);
                apply_settings(1'($urandom), scale, 1'($urandom));
            end
            send_random_request();
        end
        wait_drained();
    endtask

    always @(posedge aclk) begin
        if (backlog_left != 0) begin
            backlog_left <= backlog_left - 1;
        end
    end

    always @(posedge aclk) begin
        m_tready <= (backlog_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        feedback_result_t got;
        feedback_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = feedback_result_t'(m_tdata);
            if (pending_decodes.size() == 0) begin
                report_mismatch("result with nothing pending", m_tdata[63:0], '0);
            end else begin
                want = pending_decodes.pop_front();
                results_checked++;
                if (got.single_angle !== want.single_angle)
                    report_mismatch("single_angle", got.single_angle, want.single_angle);
                if (got.filtered_speed !== want.filtered_speed)
                    report_mismatch("filtered_speed", got.filtered_speed, want.filtered_speed);
                if (got.phase_current !== want.phase_current)
                    report_mismatch("phase_current", got.phase_current, want.phase_current);
                if (got.total_angle !== want.total_angle)
                    report_mismatch("total_angle", got.total_angle, want.total_angle);
                if (got.speed_radians !== want.speed_radians)
                    report_mismatch("speed_radians", got.speed_radians, want.speed_radians);
                if (got.temperature_out !== want.temperature_out)
                    report_mismatch("temperature_out", got.temperature_out,
                                    want.temperature_out);
                if (got.extra_out !== want.extra_out)
                    report_mismatch("extra_out", got.extra_out, want.extra_out);
                if (got.turn_count !== want.turn_count)
                    report_mismatch("turn_count", got.turn_count, want.turn_count);
                if (got.offset_angle !== want.offset_angle)
                    report_mismatch("offset_angle", got.offset_angle, want.offset_angle);
                if (got.pad !== want.pad)
                    report_mismatch("padding bit", got.pad, want.pad);
            end
        end
    end

    initial begin
        #3000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        clear_decoder();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_unwrap_boundaries();
        test_config_extremes();
        test_rezero_clear();
        test_backpressure();
        test_random_traffic(234, 31, 85);
        test_random_traffic(234, 85, 31);
        test_random_traffic(234, 0, 0);
        wait_drained();
        $display("covered %0d frames, %0d re-zero, %0d clear, %0d unused-op requests",
                 op_count[mfd_pkg::OP_FRAME], op_count[mfd_pkg::OP_REZERO],
                 op_count[mfd_pkg::OP_CLEAR], op_count[OP_UNUSED]);
        $display("%0d results checked over %0d register settings, %0d mismatches",
                 results_checked, settings_applied, mismatch_count);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[sim.f]
design/mfd_pkg.sv
design/mfd_unwrap.sv
design/mfd_speed_filter.sv
design/mfd_scale.sv
design/motor_feedback_decoder.sv
tb/sv/tb_top.sv
